/* hw/rtl/vgrm_pkg.sv */
// ----------------------------------------------------------------------------
// vgrm_pkg: shared definitions for the voxel grid ray march unit
// World geometry, field widths, item and register codes, and the microcode
// table with its control word.
// ----------------------------------------------------------------------------
package vgrm_pkg;

  // World geometry
  localparam int CHUNK_SIDE      = 16;
  localparam int CHUNKS_PER_SIDE = 4;
  localparam int WORLD_HEIGHT    = 64;
  localparam int WORLD_SIDE      = CHUNK_SIDE * CHUNKS_PER_SIDE;
  localparam int STORE_DEPTH     = WORLD_SIDE * WORLD_SIDE * WORLD_HEIGHT;
  localparam int ADDR_W          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int ORG_W     = 24;
  localparam int DIR_W     = 16;
  localparam int ID_W      = 8;
  localparam int CFG_W     = 8;
  localparam int KIND_W    = 2;
  localparam int AXIS_W    = 2;
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = ORG_W + 1;
  localparam int CELL_W    = POS_W - FRAC_BITS;
  localparam int DSTEP_W   = DIR_W + CFG_W;
  localparam int ACC_W     = 32;
  localparam int CNT_W     = CFG_W + 1;

  // Stream words
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USED_W = ID_W + 3 * COORD_W + AXIS_W + 1;
  localparam int CFG_IDX_W  = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAST   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_ID     = 2'd2;

  localparam logic [CFG_W-1:0] STEP_SIZE_RST  = 8'd51;
  localparam logic [CFG_W-1:0] STEP_COUNT_RST = 8'd50;
  localparam logic [ID_W-1:0]  AIR_ID_RST     = 8'd0;

  // Normal axes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Program steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_DISP  = 4'd1;
  localparam logic [PC_W-1:0] ST_WR    = 4'd2;
  localparam logic [PC_W-1:0] ST_RD    = 4'd3;
  localparam logic [PC_W-1:0] ST_RDOUT = 4'd4;
  localparam logic [PC_W-1:0] ST_MX    = 4'd5;
  localparam logic [PC_W-1:0] ST_MY    = 4'd6;
  localparam logic [PC_W-1:0] ST_MZ    = 4'd7;
  localparam logic [PC_W-1:0] ST_MARCH = 4'd8;
  localparam logic [PC_W-1:0] ST_HIT   = 4'd9;
  localparam logic [PC_W-1:0] ST_ZERO  = 4'd10;

  // Memory operation field
  localparam logic [1:0] MEM_NONE   = 2'd0;
  localparam logic [1:0] MEM_WR_VOX = 2'd1;
  localparam logic [1:0] MEM_RD_VOX = 2'd2;
  localparam logic [1:0] MEM_MARCH  = 2'd3;

  // Result source field
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_READ = 2'd1;
  localparam logic [1:0] RES_HIT  = 2'd2;
  localparam logic [1:0] RES_ZERO = 2'd3;

  // Jump field
  localparam logic [2:0] JMP_GOTO   = 3'd0;
  localparam logic [2:0] JMP_ACCEPT = 3'd1;
  localparam logic [2:0] JMP_KIND   = 3'd2;
  localparam logic [2:0] JMP_MARCH  = 3'd3;
  localparam logic [2:0] JMP_OUT    = 3'd4;

  typedef struct packed {
    logic              mul_en;
    logic [AXIS_W-1:0] mul_axis;
    logic              init;
    logic              march;
    logic [1:0]        mem_op;
    logic [1:0]        res_sel;
    logic [2:0]        jmp;
    logic [PC_W-1:0]   target;
  } ucw_t;

  function automatic ucw_t uword(input logic mul_en, input logic [AXIS_W-1:0] mul_axis,
                                 input logic init, input logic march,
                                 input logic [1:0] mem_op, input logic [1:0] res_sel,
                                 input logic [2:0] jmp, input logic [PC_W-1:0] target);
    ucw_t w;
    w.mul_en   = mul_en;
    w.mul_axis = mul_axis;
    w.init     = init;
    w.march    = march;
    w.mem_op   = mem_op;
    w.res_sel  = res_sel;
    w.jmp      = jmp;
    w.target   = target;
    return w;
  endfunction

  // Microcode ROM
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      ST_IDLE:  w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_NONE, JMP_ACCEPT, ST_DISP);
      ST_DISP:  w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_NONE, JMP_KIND,   ST_IDLE);
      ST_WR:    w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_WR_VOX, RES_NONE, JMP_GOTO,   ST_ZERO);
      ST_RD:    w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_RD_VOX, RES_NONE, JMP_GOTO,   ST_RDOUT);
      ST_RDOUT: w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_READ, JMP_OUT,    ST_IDLE);
      ST_MX:    w = uword(1'b1, AXIS_X, 1'b1, 1'b0, MEM_NONE,   RES_NONE, JMP_GOTO,   ST_MY);
      ST_MY:    w = uword(1'b1, AXIS_Y, 1'b0, 1'b0, MEM_NONE,   RES_NONE, JMP_GOTO,   ST_MZ);
      ST_MZ:    w = uword(1'b1, AXIS_Z, 1'b0, 1'b0, MEM_NONE,   RES_NONE, JMP_GOTO,   ST_MARCH);
      ST_MARCH: w = uword(1'b0, AXIS_X, 1'b0, 1'b1, MEM_MARCH,  RES_NONE, JMP_MARCH,  ST_HIT);
      ST_HIT:   w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_HIT,  JMP_OUT,    ST_IDLE);
      ST_ZERO:  w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_ZERO, JMP_OUT,    ST_IDLE);
      default:  w = uword(1'b0, AXIS_X, 1'b0, 1'b0, MEM_NONE,   RES_NONE, JMP_GOTO,   ST_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic in_world(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                                    input logic [CELL_W-1:0] z);
    return !x[CELL_W-1] && (x < CELL_W'(WORLD_SIDE)) &&
           !y[CELL_W-1] && (y < CELL_W'(WORLD_HEIGHT)) &&
           !z[CELL_W-1] && (z < CELL_W'(WORLD_SIDE));
  endfunction

  // Row-major index: x, then y, then z fastest
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] x,
                                                  input logic [CELL_W-1:0] y,
                                                  input logic [CELL_W-1:0] z);
    logic [ADDR_W-1:0] xa;
    logic [ADDR_W-1:0] ya;
    logic [ADDR_W-1:0] za;
    xa = ADDR_W'(x);
    ya = ADDR_W'(y);
    za = ADDR_W'(z);
    return (xa * ADDR_W'(WORLD_HEIGHT) + ya) * ADDR_W'(WORLD_SIDE) + za;
  endfunction

endpackage

/* hw/rtl/voxel_grid_ray_march_unit.sv */
// ----------------------------------------------------------------------------
// voxel_grid_ray_march_unit: voxel store with fixed-step ray march
// Holds a block id per voxel; serves voxel writes, voxel reads and ray casts
// that sample the store at regular distances along a Q.8 ray.
// ----------------------------------------------------------------------------
//
//  channel | ports                       | one word carries
//  --------+-----------------------------+------------------------------------
//  in      | in_tvalid/tready/tdata/tuser| one item: write, read or ray cast
//  out     | out_tvalid/tready/tdata/tuser| one result per item
//  cfg     | cfg_we/index/wdata          | one register write, no read-back
//
//  Sequence: a write or a read goes from acceptance through the dispatch
//  step and its store step to a result step. A ray cast runs the multiplier
//  steps MX, MY and MZ, then the march loop until a hit or the last sample,
//  then a hit or zero result step.
//  The march loop issues one store read per cycle through the
//  single memory port and checks each sample after the A and B registers.
//  Reset: rst_n clears control and registers, then a clearing pass writes the
//  reset air id into all 262144 entries, one a cycle; no item is taken meanwhile.
//  Stalls: the next item is accepted while a result waits in the output
//  register; a new result holds in its step until that register is free.
//
module voxel_grid_ray_march_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // voxel_x, voxel_y, voxel_z, new_id, origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z
  input  logic [vgrm_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind
  input  logic [vgrm_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // voxel_id, hit_x, hit_y, hit_z, normal_axis, normal_negative, zero fill
  output logic [vgrm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // hit
  output logic [0:0]                          out_tuser,
  input  logic                                cfg_we,
  input  logic [vgrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vgrm_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int COORD_W = vgrm_pkg::COORD_W;
  localparam int CELL_W  = vgrm_pkg::CELL_W;
  localparam int POS_W   = vgrm_pkg::POS_W;
  localparam int ADDR_W  = vgrm_pkg::ADDR_W;
  localparam int ID_W    = vgrm_pkg::ID_W;
  localparam int FRAC    = vgrm_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [vgrm_pkg::PC_W-1:0] pc_r, pc_nxt;
  vgrm_pkg::ucw_t            ucw;

  assign ucw = vgrm_pkg::ucode(pc_r);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [vgrm_pkg::CFG_W-1:0] step_size_r;
  logic [vgrm_pkg::CFG_W-1:0] step_count_r;
  logic [ID_W-1:0]            air_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= vgrm_pkg::STEP_SIZE_RST;
      step_count_r <= vgrm_pkg::STEP_COUNT_RST;
      air_id_r     <= vgrm_pkg::AIR_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgrm_pkg::CFG_STEP_SIZE:  step_size_r  <= cfg_wdata;
        vgrm_pkg::CFG_STEP_COUNT: step_count_r <= cfg_wdata;
        vgrm_pkg::CFG_AIR_ID:     air_id_r     <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(vgrm_pkg::STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input word capture
  // --------------------------------------------------------------------------
  logic                                in_accept;
  logic [vgrm_pkg::KIND_W-1:0]         kind_r;
  logic signed [COORD_W-1:0]           vox_r   [3];
  logic [ID_W-1:0]                     new_id_r;
  logic signed [vgrm_pkg::ORG_W-1:0]   org_r   [3];
  logic signed [vgrm_pkg::DIR_W-1:0]   dir_r   [3];

  assign in_tready = (ucw.jmp == vgrm_pkg::JMP_ACCEPT) && !clr_busy_r;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r   <= in_tuser;
      vox_r[0] <= in_tdata[15:0];
      vox_r[1] <= in_tdata[31:16];
      vox_r[2] <= in_tdata[47:32];
      new_id_r <= in_tdata[55:48];
      org_r[0] <= in_tdata[79:56];
      org_r[1] <= in_tdata[103:80];
      org_r[2] <= in_tdata[127:104];
      dir_r[0] <= in_tdata[143:128];
      dir_r[1] <= in_tdata[159:144];
      dir_r[2] <= in_tdata[175:160];
    end
  end

  // --------------------------------------------------------------------------
  // Step increment per axis: dir * step_size, one shared multiplier, one axis
  // per microcode step
  // --------------------------------------------------------------------------
  logic signed [vgrm_pkg::DIR_W-1:0]   mul_dir;
  logic signed [vgrm_pkg::DSTEP_W:0]   mul_prod;
  logic signed [vgrm_pkg::DSTEP_W-1:0] dstep_r [3];

  always_comb begin
    unique case (ucw.mul_axis)
      vgrm_pkg::AXIS_X: mul_dir = dir_r[0];
      vgrm_pkg::AXIS_Y: mul_dir = dir_r[1];
      vgrm_pkg::AXIS_Z: mul_dir = dir_r[2];
      default:          mul_dir = dir_r[0];
    endcase
    mul_prod = mul_dir * $signed({1'b0, step_size_r});
  end

  always_ff @(posedge clk) begin
    if (ucw.mul_en) begin
      unique case (ucw.mul_axis)
        vgrm_pkg::AXIS_X: dstep_r[0] <= mul_prod[vgrm_pkg::DSTEP_W-1:0];
        vgrm_pkg::AXIS_Y: dstep_r[1] <= mul_prod[vgrm_pkg::DSTEP_W-1:0];
        vgrm_pkg::AXIS_Z: dstep_r[2] <= mul_prod[vgrm_pkg::DSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // March pipeline: A = sample position, B = store read issued, then check.
  // acc holds dir * i * step_size exactly, so the floor of acc / 256 matches
  // the per-sample product.
  // --------------------------------------------------------------------------
  logic signed [vgrm_pkg::ACC_W-1:0] acc_r    [3];
  logic [vgrm_pkg::CNT_W-1:0]        i_r;
  logic                              issue;
  logic                              pa_vld_r, pa_last_r;
  logic signed [POS_W-1:0]           pa_pos_r [3];
  logic                              pb_vld_r, pb_last_r;
  logic signed [POS_W-1:0]           pb_pos_r [3];

  assign issue = (i_r <= {1'b0, step_count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
      pb_vld_r <= 1'b0;
      i_r      <= '0;
    end else if (ucw.init) begin
      pa_vld_r <= 1'b0;
      pb_vld_r <= 1'b0;
      i_r      <= '0;
    end else if (ucw.march) begin
      pa_vld_r <= issue;
      pb_vld_r <= pa_vld_r;
      if (issue) begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.init) begin
      for (int a = 0; a < 3; a++) begin
        acc_r[a] <= '0;
      end
    end else if (ucw.march) begin
      pa_last_r <= (i_r == {1'b0, step_count_r});
      pb_last_r <= pa_last_r;
      for (int a = 0; a < 3; a++) begin
        pb_pos_r[a] <= pa_pos_r[a];
        if (issue) begin
          pa_pos_r[a] <= POS_W'(org_r[a]) + POS_W'(acc_r[a] >>> FRAC);
          acc_r[a]    <= acc_r[a] + vgrm_pkg::ACC_W'(dstep_r[a]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Voxel store: one port, read data registered
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]   store_mem [vgrm_pkg::STORE_DEPTH];
  logic [CELL_W-1:0] vox_cell [3];
  logic [CELL_W-1:0] pa_cell  [3];
  logic              vox_inb, pa_inb;
  logic [ADDR_W-1:0] vox_addr, pa_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re, mem_inb;
  logic [ID_W-1:0]   mem_wdata;
  logic [ID_W-1:0]   rd_data_r;
  logic              rd_inb_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vox_cell[a] = {vox_r[a][COORD_W-1], vox_r[a]};
      pa_cell[a]  = pa_pos_r[a][POS_W-1:FRAC];
    end
    vox_inb  = vgrm_pkg::in_world(vox_cell[0], vox_cell[1], vox_cell[2]);
    vox_addr = vgrm_pkg::cell_addr(vox_cell[0], vox_cell[1], vox_cell[2]);
    pa_inb   = vgrm_pkg::in_world(pa_cell[0], pa_cell[1], pa_cell[2]);
    pa_addr  = vgrm_pkg::cell_addr(pa_cell[0], pa_cell[1], pa_cell[2]);
  end

  // Port arbitration: clearing pass first, then the microcode operation
  always_comb begin
    mem_addr  = vox_addr;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_inb   = vox_inb;
    mem_wdata = new_id_r;
    if (clr_busy_r) begin
      mem_addr  = clr_cnt_r;
      mem_we    = 1'b1;
      mem_wdata = vgrm_pkg::AIR_ID_RST;
    end else begin
      unique case (ucw.mem_op)
        vgrm_pkg::MEM_WR_VOX: mem_we = vox_inb;
        vgrm_pkg::MEM_RD_VOX: mem_re = 1'b1;
        vgrm_pkg::MEM_MARCH: begin
          mem_addr = pa_addr;
          mem_inb  = pa_inb;
          mem_re   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[mem_addr];
      rd_inb_r  <= mem_inb;
    end
  end

  // --------------------------------------------------------------------------
  // Sample check and face normal
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]              rd_id;
  logic                         samp_hit, samp_miss;
  logic [FRAC-1:0]              frac    [3];
  logic [FRAC-1:0]              off_abs [3];
  logic [2:0]                   off_pos;
  logic [vgrm_pkg::AXIS_W-1:0]  nrm_axis;
  logic                         nrm_neg;

  // Out-of-world reads see the current air id
  assign rd_id     = rd_inb_r ? rd_data_r : air_id_r;
  assign samp_hit  = pb_vld_r && (rd_id != air_id_r);
  assign samp_miss = pb_vld_r && pb_last_r && (rd_id == air_id_r);

  // Offset from the voxel centre is the fraction minus one half
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      frac[a]    = pb_pos_r[a][FRAC-1:0];
      off_abs[a] = frac[a][FRAC-1] ? (frac[a] - (FRAC'(1) << (FRAC - 1)))
                                   : ((FRAC'(1) << (FRAC - 1)) - frac[a]);
      off_pos[a] = frac[a] > (FRAC'(1) << (FRAC - 1));
    end
    priority if (off_abs[0] > off_abs[1] && off_abs[0] > off_abs[2]) begin
      nrm_axis = vgrm_pkg::AXIS_X;
      nrm_neg  = !off_pos[0];
    end else if (off_abs[1] > off_abs[2]) begin
      nrm_axis = vgrm_pkg::AXIS_Y;
      nrm_neg  = !off_pos[1];
    end else begin
      nrm_axis = vgrm_pkg::AXIS_Z;
      nrm_neg  = !off_pos[2];
    end
  end

  // Hold the hit sample once found
  logic [ID_W-1:0]             hit_id_r;
  logic [COORD_W-1:0]          hit_cell_r [3];
  logic [vgrm_pkg::AXIS_W-1:0] hit_axis_r;
  logic                        hit_neg_r;

  always_ff @(posedge clk) begin
    if (ucw.march && samp_hit) begin
      hit_id_r   <= rd_id;
      hit_axis_r <= nrm_axis;
      hit_neg_r  <= nrm_neg;
      for (int a = 0; a < 3; a++) begin
        hit_cell_r[a] <= pb_pos_r[a][FRAC+COORD_W-1:FRAC];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [ID_W-1:0]             out_id_r;
  logic [COORD_W-1:0]          out_x_r, out_y_r, out_z_r;
  logic [vgrm_pkg::AXIS_W-1:0] out_axis_r;
  logic                        out_neg_r;
  logic                        out_free, res_load;

  assign out_free = !out_valid_r || out_tready;
  assign res_load = (ucw.res_sel != vgrm_pkg::RES_NONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      unique case (ucw.res_sel)
        vgrm_pkg::RES_READ: begin
          out_hit_r  <= 1'b0;
          out_id_r   <= rd_id;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_z_r    <= '0;
          out_axis_r <= '0;
          out_neg_r  <= 1'b0;
        end
        vgrm_pkg::RES_HIT: begin
          out_hit_r  <= 1'b1;
          out_id_r   <= hit_id_r;
          out_x_r    <= hit_cell_r[0];
          out_y_r    <= hit_cell_r[1];
          out_z_r    <= hit_cell_r[2];
          out_axis_r <= hit_axis_r;
          out_neg_r  <= hit_neg_r;
        end
        default: begin
          out_hit_r  <= 1'b0;
          out_id_r   <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_z_r    <= '0;
          out_axis_r <= '0;
          out_neg_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(vgrm_pkg::OUT_DATA_W - vgrm_pkg::OUT_USED_W){1'b0}},
                       out_neg_r, out_axis_r, out_z_r, out_y_r, out_x_r, out_id_r};

  // --------------------------------------------------------------------------
  // Next step
  // --------------------------------------------------------------------------
  always_comb begin
    pc_nxt = pc_r;
    unique case (ucw.jmp)
      vgrm_pkg::JMP_GOTO:   pc_nxt = ucw.target;
      vgrm_pkg::JMP_ACCEPT: pc_nxt = in_accept ? ucw.target : pc_r;
      vgrm_pkg::JMP_KIND: begin
        unique case (kind_r)
          vgrm_pkg::KIND_WRITE: pc_nxt = vgrm_pkg::ST_WR;
          vgrm_pkg::KIND_READ:  pc_nxt = vgrm_pkg::ST_RD;
          vgrm_pkg::KIND_CAST:  pc_nxt = vgrm_pkg::ST_MX;
          default:              pc_nxt = vgrm_pkg::ST_ZERO;
        endcase
      end
      vgrm_pkg::JMP_MARCH: begin
        priority if (samp_hit) begin
          pc_nxt = ucw.target;
        end else if (samp_miss) begin
          pc_nxt = vgrm_pkg::ST_ZERO;
        end else begin
          pc_nxt = pc_r;
        end
      end
      vgrm_pkg::JMP_OUT:    pc_nxt = out_free ? ucw.target : pc_r;
      default:              pc_nxt = vgrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= vgrm_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hit_not_air: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && (ucw.res_sel == vgrm_pkg::RES_HIT) |=> out_id_r != $past(air_id_r))
    else $error("hit result carries the air id");

  a_hit_in_world: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && (ucw.res_sel == vgrm_pkg::RES_HIT) |=>
      vgrm_pkg::in_world({out_x_r[COORD_W-1], out_x_r}, {out_y_r[COORD_W-1], out_y_r},
                         {out_z_r[COORD_W-1], out_z_r}))
    else $error("hit voxel lies outside the world");

  a_hit_after_march: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == vgrm_pkg::ST_HIT) |->
      ($past(pc_r) == vgrm_pkg::ST_MARCH) || ($past(pc_r) == vgrm_pkg::ST_HIT))
    else $error("hit step entered without a march");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_cnt_r) == ADDR_W'(vgrm_pkg::STORE_DEPTH - 1))
    else $error("clearing pass ended early");

endmodule
